### sv/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### sv/modexp_pkg.sv
// Package for the modular exponentiation block: widths and state type.
// Depends on nothing; used by all modules of the block.
package modexp_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

	typedef logic [OPERAND_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

	// Operation request to the serial modular multiplier.
	typedef struct packed {
		logic  start;
		word_t x;
		word_t y;
		word_t m;
	} mm_req_t;
endpackage

### sv/modexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on modexp_pkg. Operands must already be below the modulus.
module modexp_mulmod import modexp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output logic    busy,
	output logic    done,
	output word_t   product
);
	word_t x_q, y_q, m_q, r_q;
	cnt_t  cnt_q;
	logic  busy_q, done_q;
	logic [OPERAND_WIDTH:0] dbl, dred, sum;
	word_t r_dbl, r_nxt;

	always_comb begin
		dbl   = {r_q, 1'b0};
		dred  = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		r_dbl = dred[OPERAND_WIDTH-1:0];
		sum   = {1'b0, r_dbl} + {1'b0, x_q};
		if (y_q[OPERAND_WIDTH-1]) begin
			r_nxt = (sum >= {1'b0, m_q}) ? OPERAND_WIDTH'(sum - {1'b0, m_q})
				: sum[OPERAND_WIDTH-1:0];
		end else begin
			r_nxt = r_dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OPERAND_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x;
			y_q <= req.y;
			m_q <= req.m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_nxt;
			y_q <= {y_q[OPERAND_WIDTH-2:0], 1'b0};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = r_q;
endmodule

### sv/modexp_reduce.sv
// Bit-serial reduction of a word modulo the modulus, one dividend bit a cycle.
// Depends on modexp_pkg.
module modexp_reduce import modexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t value,
	input  word_t m,
	output logic  done,
	output word_t remainder
);
	word_t v_q, m_q, r_q;
	cnt_t  cnt_q;
	logic  busy_q, done_q;
	logic [OPERAND_WIDTH:0] sh;
	word_t r_nxt;

	always_comb begin
		sh    = {r_q, v_q[OPERAND_WIDTH-1]};
		r_nxt = (sh >= {1'b0, m_q}) ? OPERAND_WIDTH'(sh - {1'b0, m_q})
			: sh[OPERAND_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OPERAND_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_nxt;
			v_q <= {v_q[OPERAND_WIDTH-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = r_q;
endmodule

### sv/modular_exponentiation_top.sv
// Channel | signals                                   | direction
// request | valid, stall, base_value, exponent, modulus | in (stall out)
// result  | out_valid, out_stall, power_result, zero_modulus_error | out (out_stall in)
//
// A request first reduces the base. Each exponent bit then costs one multiply (only when
// set) and one squaring in the shared bit-serial multiplier; the exponent is scanned
// until no set bit remains. A zero modulus finishes at once; a zero reduced base or a
// zero exponent finishes after the reduction step.
// arst_n clears the controller; the result register holds while out_stall is high.
// Depends on modexp_pkg, modexp_reduce, modexp_mulmod and assert_macros.svh.
`include "assert_macros.svh"
module modular_exponentiation_top import modexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid,
	output logic  stall,
	input  word_t base_value,
	input  word_t exponent,
	input  word_t modulus,
	output logic  out_valid,
	input  logic  out_stall,
	output word_t power_result,
	output logic  zero_modulus_error
);
	state_t  state_q, state_d;
	word_t   e_q, m_q, a_q, acc_q, res_q;
	logic    err_q, ov_q;
	logic    red_start, red_done, mm_busy, mm_done;
	word_t   red_rem, mm_prod;
	mm_req_t mm_req;
	logic    accept;

	// A new request is taken only when idle and the result register is free.
	assign accept = valid && !stall;
	assign stall  = (state_q != ST_IDLE) || ov_q;

	modexp_reduce u_red (
		.clk(clk), .arst_n(arst_n), .start(red_start), .value(base_value),
		.m(modulus), .done(red_done), .remainder(red_rem)
	);

	modexp_mulmod u_mm (
		.clk(clk), .arst_n(arst_n), .req(mm_req), .busy(mm_busy),
		.done(mm_done), .product(mm_prod)
	);

	// The reduction starts in the acceptance cycle with the port values, unless the modulus is zero.
	assign red_start = accept && (modulus != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mm_req.start = 1'b0;
		mm_req.x     = acc_q;
		mm_req.y     = a_q;
		mm_req.m     = m_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (modulus == '0) ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done) begin
					if (red_rem == '0 || e_q == '0) begin
						state_d = ST_DONE;
					end else if (e_q[0]) begin
						state_d      = ST_MUL;
						mm_req.start = 1'b1;
						mm_req.x     = acc_q;
						mm_req.y     = red_rem;
					end else begin
						state_d      = ST_SQR;
						mm_req.start = 1'b1;
						mm_req.x     = red_rem;
						mm_req.y     = red_rem;
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					state_d      = ST_SQR;
					mm_req.start = 1'b1;
					mm_req.x     = a_q;
					mm_req.y     = a_q;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					// e_q already shifted; decide on the next bit.
					if (e_q == '0) begin
						state_d = ST_DONE;
					end else if (e_q[0]) begin
						state_d      = ST_MUL;
						mm_req.start = 1'b1;
						mm_req.x     = acc_q;
						mm_req.y     = mm_prod;
					end else begin
						state_d      = ST_SQR;
						mm_req.start = 1'b1;
						mm_req.x     = mm_prod;
						mm_req.y     = mm_prod;
					end
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath: accumulator, running square and exponent shift register.
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= exponent;
			m_q   <= modulus;
			acc_q <= OPERAND_WIDTH'(1);
			err_q <= (modulus == '0);
		end
		if (state_q == ST_REDUCE && red_done) begin
			a_q <= red_rem;
			if (red_rem == '0) begin
				acc_q <= '0;
			end
		end
		if (state_q == ST_MUL && mm_done) begin
			acc_q <= mm_prod;
		end
		if (state_q == ST_SQR && mm_done) begin
			a_q <= mm_prod;
		end
		// The exponent moves on as each squaring starts.
		if (mm_req.start && state_d == ST_SQR) begin
			e_q <= {1'b0, e_q[OPERAND_WIDTH-1:1]};
		end
	end

	// Output register, loaded when the controller finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			ov_q <= 1'b1;
		end else if (ov_q && !out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			res_q <= err_q ? '0 : acc_q;
		end
	end

	assign out_valid          = ov_q;
	assign power_result       = res_q;
	assign zero_modulus_error = err_q;

	`ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, stall, "accepted while busy")
	`ASSERT_IMP(a_err_zero, clk, arst_n, ov_q && err_q, power_result == '0, "error result nonzero")
	`ASSERT_NXT(a_done_valid, clk, arst_n, state_q == ST_DONE, out_valid, "result lost")
	`ASSERT_IMP(a_mm_idle, clk, arst_n, mm_req.start, !mm_busy, "multiplier restarted")
endmodule
